>>> hdl/ptflr_pkg.sv
// ----------------------------------------------------------------------------
// ptflr_pkg
// Shared types, constants and helpers for the associative page table with
// FIFO / LRU replacement.
// ----------------------------------------------------------------------------
package ptflr_pkg;

   localparam int FRAMES   = 16;
   localparam int FRAME_W  = $clog2(FRAMES);
   localparam int RANK_CAP = 2 * FRAMES - 1;
   localparam int RANK_W   = $clog2(2 * FRAMES);
   localparam int PAGE_W   = 20;
   localparam int PID_W    = 16;
   localparam int CNT_W    = 5;
   localparam int REQ_W    = 2;

   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
   localparam logic [REQ_W-1:0] REQ_COUNT  = 2'd2;

   localparam logic MODE_FIFO = 1'b0;
   localparam logic MODE_LRU  = 1'b1;

   // partial results handed from cell to cell
   typedef struct packed {
      logic               free_found;
      logic [FRAME_W-1:0] free_idx;
      logic [RANK_W-1:0]  free_rank;
      logic               best_set;
      logic [FRAME_W-1:0] best_idx;
      logic [RANK_W-1:0]  best_rank;
      logic [PID_W-1:0]   best_owner;
      logic               hit;
      logic [CNT_W-1:0]   count;
   } scan_type;

   // request and update broadcast to every cell
   typedef struct packed {
      logic               we;
      logic               mode;
      logic [FRAME_W-1:0] slot;
      logic [RANK_W-1:0]  old_rank;
      logic [PAGE_W-1:0]  page;
      logic [PID_W-1:0]   pid;
   } bcast_type;

   function automatic logic [RANK_W-1:0] rank_inc(input logic [RANK_W-1:0] r);
      logic [RANK_W-1:0] cap;
      cap = RANK_W'(RANK_CAP);
      return (r >= cap) ? cap : r + RANK_W'(1);
   endfunction

endpackage

>>> hdl/page_table_fifo_lru_replace.sv
// ----------------------------------------------------------------------------
// page_table_fifo_lru_replace
// Fully associative page table of FRAMES frames with FIFO or LRU replacement.
//
// Usage: requests enter on req_valid/req_ready (insert, lookup, count) with
// a page number and process id; exactly one result leaves per request on
// rsp_valid/rsp_ready. The replacement policy is set by csr_wr_en/csr_wr_data;
// the user writes it only while the block is idle; the block does not enforce this.
// A request walks the row of frame cells one cell per cycle, collecting the
// first free frame, the oldest frame, the hit flag and the owner count. Once
// the scan has passed the last cell and the output register is free, the DONE
// state registers the result and, for an insert, writes the frame and updates
// the ranks. No new request is taken until the block is back in idle.
// A result waiting in the output register does not block the next request;
// if the receiver still stalls when the next result is ready, the block holds
// that result and its table update until the output register frees up.
// Reset clears all valid bits and ranks and selects FIFO mode.
// ----------------------------------------------------------------------------
module page_table_fifo_lru_replace (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic                          csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ptflr_pkg::REQ_W-1:0]   req_type,
   input  logic [ptflr_pkg::PAGE_W-1:0]  req_page_number,
   input  logic [ptflr_pkg::PID_W-1:0]   req_process_id,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic                          rsp_evicted,
   output logic [ptflr_pkg::PID_W-1:0]   rsp_evicted_owner,
   output logic [ptflr_pkg::CNT_W-1:0]   rsp_frame_count
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [ptflr_pkg::FRAME_W-1:0] cnt_ff, cnt_in;
   logic                          mode_ff;
   logic [ptflr_pkg::REQ_W-1:0]   type_ff;
   logic [ptflr_pkg::PAGE_W-1:0]  page_ff;
   logic [ptflr_pkg::PID_W-1:0]   pid_ff;

   logic                          rsp_valid_ff;
   logic                          hit_ff, hit_in;
   logic                          evicted_ff, evicted_in;
   logic [ptflr_pkg::PID_W-1:0]   owner_ff, owner_in;
   logic [ptflr_pkg::CNT_W-1:0]   count_ff, count_in;

   ptflr_pkg::scan_type           chain [0:ptflr_pkg::FRAMES];
   ptflr_pkg::scan_type           res;
   ptflr_pkg::bcast_type          bcast;
   logic                          out_free;
   logic                          finish;

   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign finish    = (state_ff == ST_DONE) && out_free;

   assign chain[0] = '0;
   assign res      = chain[ptflr_pkg::FRAMES];

   genvar gi;
   generate
      for (gi = 0; gi < ptflr_pkg::FRAMES; gi++) begin : g_cell
         ptflr_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cell_index (ptflr_pkg::FRAME_W'(gi)),
            .bcast      (bcast),
            .scan_in    (chain[gi]),
            .scan_out   (chain[gi+1])
         );
      end
   endgenerate

   always_comb begin
      bcast.we       = finish && (type_ff == ptflr_pkg::REQ_INSERT);
      bcast.mode     = mode_ff;
      bcast.slot     = res.free_found ? res.free_idx  : res.best_idx;
      bcast.old_rank = res.free_found ? res.free_rank : res.best_rank;
      bcast.page     = page_ff;
      bcast.pid      = pid_ff;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + ptflr_pkg::FRAME_W'(1);
            if (cnt_ff == ptflr_pkg::FRAME_W'(ptflr_pkg::FRAMES - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      hit_in     = 1'b0;
      evicted_in = 1'b0;
      owner_in   = '0;
      count_in   = '0;
      case (type_ff)
         ptflr_pkg::REQ_INSERT: begin
            evicted_in = !res.free_found;
            owner_in   = res.free_found ? '0 : res.best_owner;
         end
         ptflr_pkg::REQ_LOOKUP: hit_in   = res.hit;
         ptflr_pkg::REQ_COUNT:  count_in = res.count;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         mode_ff      <= ptflr_pkg::MODE_FIFO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_wr_en) mode_ff <= csr_wr_data;
         if (finish) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         type_ff <= req_type;
         page_ff <= req_page_number;
         pid_ff  <= req_process_id;
      end
      if (finish) begin
         hit_ff     <= hit_in;
         evicted_ff <= evicted_in;
         owner_ff   <= owner_in;
         count_ff   <= count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_evicted       = evicted_ff;
   assign rsp_evicted_owner = owner_ff;
   assign rsp_frame_count   = count_ff;

endmodule

>>> hdl/ptflr_cell.sv
// ----------------------------------------------------------------------------
// ptflr_cell
// One frame of the page table: valid, page, owner and rank, plus one
// registered stage of the scan that walks the row of frames.
// ----------------------------------------------------------------------------
module ptflr_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ptflr_pkg::FRAME_W-1:0] cell_index,
   input  ptflr_pkg::bcast_type          bcast,
   input  ptflr_pkg::scan_type           scan_in,
   output ptflr_pkg::scan_type           scan_out
);

   logic                          valid_ff, valid_in;
   logic [ptflr_pkg::PAGE_W-1:0]  page_ff;
   logic [ptflr_pkg::PID_W-1:0]   owner_ff;
   logic [ptflr_pkg::RANK_W-1:0]  rank_ff, rank_in;
   ptflr_pkg::scan_type           scan_ff, scan_in_next;
   logic                          own_match;
   logic                          sel;

   assign own_match = valid_ff && (owner_ff == bcast.pid);
   assign sel       = bcast.we && (bcast.slot == cell_index);

   always_comb begin
      scan_in_next = scan_in;
      if (!scan_in.free_found && !valid_ff) begin
         scan_in_next.free_found = 1'b1;
         scan_in_next.free_idx   = cell_index;
         scan_in_next.free_rank  = rank_ff;
      end
      if (!scan_in.best_set || (rank_ff > scan_in.best_rank)) begin
         scan_in_next.best_set   = 1'b1;
         scan_in_next.best_idx   = cell_index;
         scan_in_next.best_rank  = rank_ff;
         scan_in_next.best_owner = owner_ff;
      end
      if (own_match && (page_ff == bcast.page)) begin
         scan_in_next.hit = 1'b1;
      end
      if (own_match) begin
         scan_in_next.count = scan_in.count + ptflr_pkg::CNT_W'(1);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (bcast.we) begin
         if (sel) begin
            valid_in = 1'b1;
            rank_in  = (bcast.mode == ptflr_pkg::MODE_LRU) ?
                       ptflr_pkg::RANK_W'(0) : ptflr_pkg::RANK_W'(1);
         end else if (bcast.mode == ptflr_pkg::MODE_LRU) begin
            if (rank_ff <= bcast.old_rank) rank_in = ptflr_pkg::rank_inc(rank_ff);
         end else begin
            if (rank_ff != ptflr_pkg::RANK_W'(0)) rank_in = ptflr_pkg::rank_inc(rank_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sel) begin
         page_ff  <= bcast.page;
         owner_ff <= bcast.pid;
      end
      scan_ff <= scan_in_next;
   end

   assign scan_out = scan_ff;

endmodule

>>> verif/page_table_fifo_lru_replace_tb.sv
// ----------------------------------------------------------------------------
// page_table_fifo_lru_replace_tb
// Checks the associative page table with FIFO / LRU replacement. Inserts,
// lookups, counts and unused request codes go in on the req channel. A model
// of the frame table works out each response as its request is taken, and the
// responses on the rsp channel are compared field by field, in order. The
// replacement mode is switched between phases while the table stays full.
// Both channels idle at random, except in one phase where they never idle.
// ----------------------------------------------------------------------------
module page_table_fifo_lru_replace_tb;
   import ptflr_pkg::*;

   localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
   localparam int DRAIN_CYCLES = FRAMES + 8;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 100;

   typedef struct packed {
      logic [REQ_W-1:0]  kind;
      logic [PAGE_W-1:0] page;
      logic [PID_W-1:0]  pid;
   } page_req_t;

   typedef struct packed {
      logic             hit;
      logic             evicted;
      logic [PID_W-1:0] owner;
      logic [CNT_W-1:0] count;
   } page_rsp_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic                csr_wr_data = 1'b0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [REQ_W-1:0]    req_type = '0;
   logic [PAGE_W-1:0]   req_page_number = '0;
   logic [PID_W-1:0]    req_process_id = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_hit;
   logic                rsp_evicted;
   logic [PID_W-1:0]    rsp_evicted_owner;
   logic [CNT_W-1:0]    rsp_frame_count;

   page_req_t           pending_reqs[$];
   page_rsp_t           predicted_rsps[$];
   page_req_t           req_now;
   bit                  req_loaded = 1'b0;
   int unsigned         idle_pct = 30;
   int                  error_count = 0;
   int                  cycle_count = 0;

   // frame table model
   logic                tbl_mode = MODE_FIFO;
   logic                tbl_valid[FRAMES];
   logic [PAGE_W-1:0]   tbl_page[FRAMES];
   logic [PID_W-1:0]    tbl_owner[FRAMES];
   logic [RANK_W-1:0]   tbl_rank[FRAMES];

   page_table_fifo_lru_replace u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_page_number   (req_page_number),
      .req_process_id    (req_process_id),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_evicted       (rsp_evicted),
      .rsp_evicted_owner (rsp_evicted_owner),
      .rsp_frame_count   (rsp_frame_count)
   );

   always #2 clock = ~clock;

   initial begin
      for (int i = 0; i < FRAMES; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_page[i]  = '0;
         tbl_owner[i] = '0;
         tbl_rank[i]  = '0;
      end
   end

   function automatic logic [RANK_W-1:0] rank_bump(logic [RANK_W-1:0] r);
      if (r >= RANK_W'(RANK_CAP))
         return RANK_W'(RANK_CAP);
      return r + RANK_W'(1);
   endfunction

   function automatic page_rsp_t apply_to_table(page_req_t r);
      page_rsp_t         o;
      int                i;
      int                slot;
      bit                found;
      logic [RANK_W-1:0] top;
      logic [RANK_W-1:0] old;
      o = '0;
      case (r.kind)
         REQ_INSERT: begin
            found = 1'b0;
            slot  = 0;
            for (i = 0; i < FRAMES; i++)
               if (!found && !tbl_valid[i]) begin
                  found = 1'b1;
                  slot  = i;
               end
            if (!found) begin
               top = '0;
               for (i = 0; i < FRAMES; i++)
                  if (tbl_rank[i] > top) begin
                     top  = tbl_rank[i];
                     slot = i;
                  end
               o.evicted = 1'b1;
               o.owner   = tbl_owner[slot];
            end
            tbl_valid[slot] = 1'b1;
            tbl_page[slot]  = r.page;
            tbl_owner[slot] = r.pid;
            if (tbl_mode == MODE_LRU) begin
               old = tbl_rank[slot];
               for (i = 0; i < FRAMES; i++)
                  if (tbl_rank[i] <= old)
                     tbl_rank[i] = rank_bump(tbl_rank[i]);
               tbl_rank[slot] = '0;
            end else begin
               for (i = 0; i < FRAMES; i++)
                  if (tbl_rank[i] != '0)
                     tbl_rank[i] = rank_bump(tbl_rank[i]);
               tbl_rank[slot] = RANK_W'(1);
            end
         end
         REQ_LOOKUP: begin
            for (i = 0; i < FRAMES; i++)
               if (tbl_valid[i] && tbl_owner[i] == r.pid && tbl_page[i] == r.page)
                  o.hit = 1'b1;
         end
         REQ_COUNT: begin
            for (i = 0; i < FRAMES; i++)
               if (tbl_valid[i] && tbl_owner[i] == r.pid)
                  o.count = o.count + CNT_W'(1);
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic report_error(string what);
      error_count++;
      if (error_count <= 100)
         $display("ERROR cycle %0d: %s", cycle_count, what);
   endtask

   task automatic push_req(logic [REQ_W-1:0] kind, logic [PAGE_W-1:0] page,
                           logic [PID_W-1:0] pid);
      page_req_t item;
      item.kind = kind;
      item.page = page;
      item.pid  = pid;
      pending_reqs.push_back(item);
   endtask

   task automatic wait_drained();
      while (req_loaded || pending_reqs.size() != 0 || predicted_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(logic m);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tbl_mode = m;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_rsps.push_back(apply_to_table(req_now));
            req_loaded = 1'b0;
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_now    = pending_reqs.pop_front();
               req_loaded = 1'b1;
               req_valid       <= 1'b1;
               req_type        <= req_now.kind;
               req_page_number <= req_now.page;
               req_process_id  <= req_now.pid;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      page_rsp_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsps.size() == 0) begin
               report_error("response with no request outstanding");
            end else begin
               want = predicted_rsps.pop_front();
               if (rsp_hit !== want.hit)
                  report_error($sformatf("hit got %0b want %0b", rsp_hit, want.hit));
               if (rsp_evicted !== want.evicted)
                  report_error($sformatf("evicted got %0b want %0b",
                                         rsp_evicted, want.evicted));
               if (rsp_evicted_owner !== want.owner)
                  report_error($sformatf("evicted_owner got %h want %h",
                                         rsp_evicted_owner, want.owner));
               if (rsp_frame_count !== want.count)
                  report_error($sformatf("frame_count got %0d want %0d",
                                         rsp_frame_count, want.count));
            end
         end
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** page_table_fifo_lru_replace: FAILED **");
         $finish;
      end
   end

   initial begin
      int                ph;
      int                n;
      int                roll;
      int                npid;
      int                npage;
      logic [REQ_W-1:0]  kind;
      logic [PAGE_W-1:0] page;
      logic [PID_W-1:0]  pid;
      logic [PID_W-1:0]  pid_pool[4];
      logic [PAGE_W-1:0] page_pool[8];

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // LRU while frames are still free
      set_mode(MODE_LRU);
      push_req(REQ_LOOKUP, '0, '0);
      push_req(REQ_COUNT, '0, '0);
      push_req(REQ_UNKNOWN, '1, '1);
      push_req(REQ_INSERT, '1, '1);
      for (n = 0; n < 7; n++)
         push_req(REQ_INSERT, PAGE_W'(n), '1);
      wait_drained();

      // FIFO fills the rest, then evicts
      set_mode(MODE_FIFO);
      for (n = 7; n < 15; n++)
         push_req(REQ_INSERT, PAGE_W'(n), '1);
      push_req(REQ_COUNT, '0, '1);
      push_req(REQ_LOOKUP, '1, '1);
      push_req(REQ_LOOKUP, '1, '0);
      push_req(REQ_INSERT, '0, '0);

      for (ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         idle_pct = (ph == 5) ? 0 : 30;
         if (ph == 0)
            set_mode(MODE_LRU);
         else if (ph == 1)
            set_mode(MODE_FIFO);
         else
            set_mode(logic'($urandom_range(1)));
         npid  = $urandom_range(1, 4);
         npage = $urandom_range(2, 8);
         for (n = 0; n < 4; n++)
            pid_pool[n] = PID_W'($urandom_range(16'hFFFF));
         for (n = 0; n < 8; n++)
            page_pool[n] = PAGE_W'($urandom_range(20'hFFFFF));
         for (n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(99);
            if (roll < 45)
               kind = REQ_INSERT;
            else if (roll < 75)
               kind = REQ_LOOKUP;
            else if (roll < 95)
               kind = REQ_COUNT;
            else
               kind = REQ_UNKNOWN;
            if ($urandom_range(9) == 0)
               pid = PID_W'($urandom_range(16'hFFFF));
            else
               pid = pid_pool[$urandom_range(npid - 1)];
            if ($urandom_range(9) == 0)
               page = PAGE_W'($urandom_range(20'hFFFFF));
            else
               page = page_pool[$urandom_range(npage - 1)];
            push_req(kind, page, pid);
         end
      end

      wait_drained();
      if (error_count == 0)
         $display("** page_table_fifo_lru_replace: PASSED **");
      else
         $display("** page_table_fifo_lru_replace: FAILED **");
      $finish;
   end

endmodule
